### hdl/aif_pkg.sv
// Shared types and constants for the audio interface register block.
package aif_pkg;

    // Command codes.
    localparam logic [1:0] CMD_READ  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_TICK  = 2'd2;
    localparam logic [1:0] CMD_NOP   = 2'd3;

    // Register offsets on the bus.
    localparam logic [15:0] OFS_CONTROL = 16'h6C00;
    localparam logic [15:0] OFS_VOLUME  = 16'h6C04;
    localparam logic [15:0] OFS_COUNTER = 16'h6C08;
    localparam logic [15:0] OFS_TARGET  = 16'h6C0C;

    // Control word bit positions.
    localparam int CTL_PLAY   = 0;
    localparam int CTL_RATE   = 1;
    localparam int CTL_MASK   = 2;
    localparam int CTL_STATUS = 3;
    localparam int CTL_MATCH  = 4;
    localparam int CTL_STROBE = 5;
    localparam int CTL_DMA    = 6;

    // Configuration register indexes.
    localparam logic CFG_FAST = 1'b0;
    localparam logic CFG_SLOW = 1'b1;

    localparam int PERIOD_W = 20;
    localparam logic [PERIOD_W-1:0] PERIOD_FAST_RST = 20'd10125;
    localparam logic [PERIOD_W-1:0] PERIOD_SLOW_RST = 20'd15187;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [15:0] reg_offset;
        logic [31:0] write_data;
    } t_aif_in;

    typedef struct packed {
        logic [31:0] read_data;
        logic        bad_offset;
        logic        irq_line;
        logic        stream_enable;
        logic        dma_rate_slow;
    } t_aif_out;

    // Configuration write bundle from the top level to the core.
    typedef struct packed {
        logic                we;
        logic                idx;
        logic [PERIOD_W-1:0] data;
    } t_aif_cfg;

endpackage

### hdl/audio_interface_registers.sv
// Top level of the audio interface register block.
//
//  port group      direction  handshake                   word
//  i_in            in         i_in_valid / o_in_ready     cmd, reg_offset, write_data
//  o_out           out        o_out_valid / i_out_ready   read_data, flags
//  i_cfg_*         in         i_cfg_we (no wait)          20-bit period value
//
// A word's result is in the result register once the word has passed the
// input register: the core works on the input register and the result register
// takes its output when it has room. One word per cycle is sustained while the
// consumer does not stall; the core's register update is the only loop.
// Reset is synchronous and active low; valid flags and core state return to defaults, held data words are not reset.
// A stalled consumer holds the result register, and the input register then
// fills, after which o_in_ready drops until the result is taken.
module audio_interface_registers import aif_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  t_aif_in             i_in,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output t_aif_out            o_out,
    input  logic                i_cfg_we,
    input  logic                i_cfg_idx,
    input  logic [PERIOD_W-1:0] i_cfg_data
);

    logic     w_stage_valid;
    t_aif_in  w_stage_word;
    logic     w_out_free;
    logic     w_advance;
    t_aif_out w_result;
    t_aif_cfg w_cfg;

    assign w_advance = w_stage_valid && w_out_free;

    assign w_cfg.we   = i_cfg_we;
    assign w_cfg.idx  = i_cfg_idx;
    assign w_cfg.data = i_cfg_data;

    aif_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .i_word    (i_in),
        .o_ready   (o_in_ready),
        .i_advance (w_advance),
        .o_valid   (w_stage_valid),
        .o_word    (w_stage_word)
    );

    aif_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (w_cfg),
        .i_step   (w_advance),
        .i_item   (w_stage_word),
        .o_result (w_result)
    );

    aif_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_advance),
        .i_word  (w_result),
        .o_free  (w_out_free),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_word  (o_out)
    );

    // An empty result register never blocks the input side.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with an empty result register");

    // A staged word with room downstream shows up as a result next cycle.
    a_stage_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stage_valid && w_out_free |=> o_out_valid)
        else $error("staged word did not reach the result register");

    // An unknown offset never returns data.
    a_bad_reads_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.bad_offset |-> o_out.read_data == 32'd0)
        else $error("bad offset returned nonzero data");

endmodule

### hdl/aif_in_reg.sv
// Input register stage: holds one accepted command word for the core.
module aif_in_reg import aif_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_aif_in i_word,
    output logic    o_ready,
    input  logic    i_advance,
    output logic    o_valid,
    output t_aif_in o_word
);

    logic    r_valid;
    logic    n_valid;
    t_aif_in r_word;

    assign o_ready = !r_valid || i_advance;
    assign o_valid = r_valid;
    assign o_word  = r_word;

    always_comb begin
        n_valid = r_valid;
        if (i_valid && o_ready) begin
            n_valid = 1'b1;
        end else if (i_advance) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_word <= i_word;
        end
    end

endmodule

### hdl/aif_core.sv
// Register file, sample timer and result logic for one command word.
module aif_core import aif_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_aif_cfg i_cfg,
    input  logic     i_step,
    input  t_aif_in  i_item,
    output t_aif_out o_result
);

    logic [PERIOD_W-1:0] r_period_fast, r_period_slow;

    logic                r_play, r_rate_fast, r_mask, r_status, r_match, r_dma;
    logic [31:0]         r_volume, r_count, r_target;
    logic [PERIOD_W-1:0] r_accum;

    logic                n_play, n_rate_fast, n_mask, n_status, n_match, n_dma;
    logic [31:0]         n_volume, n_count, n_target;
    logic [PERIOD_W-1:0] n_accum;

    logic [PERIOD_W-1:0] w_period;
    logic [PERIOD_W-1:0] w_accum_inc;
    logic [31:0]         w_count_inc;
    logic [31:0]         w_read;
    logic                w_bad;
    logic [31:0]         w_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period_fast <= PERIOD_FAST_RST;
            r_period_slow <= PERIOD_SLOW_RST;
        end else if (i_cfg.we) begin
            if (i_cfg.idx == CFG_FAST) begin
                r_period_fast <= i_cfg.data;
            end else begin
                r_period_slow <= i_cfg.data;
            end
        end
    end

    assign w_data = i_item.write_data;

    always_comb begin
        w_period = r_rate_fast ? r_period_fast : r_period_slow;
        // A period of zero behaves as a period of one.
        if (w_period == '0) begin
            w_period = PERIOD_W'(1);
        end
        w_accum_inc = r_accum + PERIOD_W'(1);
        w_count_inc = r_count + 32'd1;
    end

    always_comb begin
        n_play      = r_play;
        n_rate_fast = r_rate_fast;
        n_mask      = r_mask;
        n_status    = r_status;
        n_match     = r_match;
        n_dma       = r_dma;
        n_volume    = r_volume;
        n_count     = r_count;
        n_target    = r_target;
        n_accum     = r_accum;
        w_read      = '0;
        w_bad       = 1'b0;
        case (i_item.cmd)
            CMD_READ: begin
                case (i_item.reg_offset)
                    OFS_CONTROL: w_read = {25'd0, r_dma, 1'b0, r_match, r_status,
                                           r_mask, r_rate_fast, r_play};
                    OFS_VOLUME:  w_read = r_volume;
                    OFS_COUNTER: w_read = r_count;
                    OFS_TARGET:  w_read = r_target;
                    default:     w_bad  = 1'b1;
                endcase
            end
            CMD_WRITE: begin
                case (i_item.reg_offset)
                    OFS_CONTROL: begin
                        n_mask      = w_data[CTL_MASK];
                        n_match     = w_data[CTL_MATCH];
                        n_rate_fast = w_data[CTL_RATE];
                        n_dma       = w_data[CTL_DMA];
                        n_play      = w_data[CTL_PLAY];
                        if (w_data[CTL_PLAY] != r_play) begin
                            n_accum = '0;
                        end
                        if (w_data[CTL_STATUS]) begin
                            n_status = 1'b0;
                        end
                        if (w_data[CTL_STROBE]) begin
                            n_count = '0;
                            n_accum = '0;
                        end
                    end
                    OFS_VOLUME:  n_volume = w_data;
                    OFS_COUNTER: n_count  = w_data;
                    OFS_TARGET:  n_target = w_data;
                    default:     w_bad    = 1'b1;
                endcase
            end
            CMD_TICK: begin
                if (r_play) begin
                    if (w_accum_inc >= w_period) begin
                        n_accum = '0;
                        n_count = w_count_inc;
                        if (r_match && (w_count_inc >= r_target)) begin
                            n_status = 1'b1;
                        end
                    end else begin
                        n_accum = w_accum_inc;
                    end
                end
            end
            CMD_NOP: begin
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_result.read_data     = w_read;
        o_result.bad_offset    = w_bad;
        o_result.irq_line      = n_status && n_mask;
        o_result.stream_enable = n_play;
        o_result.dma_rate_slow = n_dma;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_play      <= 1'b0;
            r_rate_fast <= 1'b1;
            r_mask      <= 1'b0;
            r_status    <= 1'b0;
            r_match     <= 1'b0;
            r_dma       <= 1'b0;
            r_volume    <= '0;
            r_count     <= '0;
            r_target    <= '0;
            r_accum     <= '0;
        end else if (i_step) begin
            r_play      <= n_play;
            r_rate_fast <= n_rate_fast;
            r_mask      <= n_mask;
            r_status    <= n_status;
            r_match     <= n_match;
            r_dma       <= n_dma;
            r_volume    <= n_volume;
            r_count     <= n_count;
            r_target    <= n_target;
            r_accum     <= n_accum;
        end
    end

endmodule

### hdl/aif_out_reg.sv
// Result register stage: holds one result word until the consumer takes it.
module aif_out_reg import aif_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_load,
    input  t_aif_out i_word,
    output logic     o_free,
    output logic     o_valid,
    input  logic     i_ready,
    output t_aif_out o_word
);

    logic     r_valid;
    logic     n_valid;
    t_aif_out r_word;

    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_word  = r_word;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_word <= i_word;
        end
    end

endmodule

### tb/audio_interface_registers_tb.sv
// Self-checking testbench for the audio interface register block.
`timescale 1ns / 100ps

module audio_interface_registers_tb;
    import aif_pkg::*;

    localparam int WORDS_PER_PHASE = 413;
    localparam int REPORT_LIMIT    = 10;
    localparam int DRAIN_LIMIT     = 200000;

    logic                i_clk;
    logic                i_rst_n;
    logic                in_valid;
    logic                o_in_ready;
    t_aif_in             in_word;
    logic                o_out_valid;
    logic                out_ready;
    t_aif_out            o_out;
    logic                cfg_we;
    logic                cfg_idx;
    logic [PERIOD_W-1:0] cfg_data;

    audio_interface_registers u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (in_valid),
        .o_in_ready    (o_in_ready),
        .i_in          (in_word),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (out_ready),
        .o_out         (o_out),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_data    (cfg_data)
    );

    // Shadow copy of the register file and the sample timing state.
    logic [PERIOD_W-1:0] period_fast = PERIOD_FAST_RST;
    logic [PERIOD_W-1:0] period_slow = PERIOD_SLOW_RST;
    logic                m_play      = 1'b0;
    logic                m_rate_fast = 1'b1;
    logic                m_mask      = 1'b0;
    logic                m_status    = 1'b0;
    logic                m_match     = 1'b0;
    logic                m_dma       = 1'b0;
    logic [31:0]         m_vol_word  = '0;
    logic [31:0]         m_count     = '0;
    logic [31:0]         m_target    = '0;
    logic [PERIOD_W-1:0] m_accum     = '0;

    t_aif_out expected_words[$];
    t_aif_out oldest_word;
    int       fault_count   = 0;
    int       send_idle_pct = 0;
    int       recv_stall_pct = 0;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Advances the shadow state by one bus word and returns the status word it produces.
    function automatic t_aif_out apply_bus_word(input t_aif_in w);
        t_aif_out            r;
        logic [PERIOD_W-1:0] span;
        r = '0;
        case (w.cmd)
            CMD_READ: begin
                case (w.reg_offset)
                    OFS_CONTROL: r.read_data = {25'd0, m_dma, 1'b0, m_match, m_status,
                                                m_mask, m_rate_fast, m_play};
                    OFS_VOLUME:  r.read_data = m_vol_word;
                    OFS_COUNTER: r.read_data = m_count;
                    OFS_TARGET:  r.read_data = m_target;
                    default:     r.bad_offset = 1'b1;
                endcase
            end
            CMD_WRITE: begin
                case (w.reg_offset)
                    OFS_CONTROL: begin
                        m_mask      = w.write_data[CTL_MASK];
                        m_match     = w.write_data[CTL_MATCH];
                        m_rate_fast = w.write_data[CTL_RATE];
                        m_dma       = w.write_data[CTL_DMA];
                        if (w.write_data[CTL_PLAY] != m_play) begin
                            m_play  = w.write_data[CTL_PLAY];
                            m_accum = '0;
                        end
                        if (w.write_data[CTL_STATUS])
                            m_status = 1'b0;
                        if (w.write_data[CTL_STROBE]) begin
                            m_count = '0;
                            m_accum = '0;
                        end
                    end
                    OFS_VOLUME:  m_vol_word = w.write_data;
                    OFS_COUNTER: m_count  = w.write_data;
                    OFS_TARGET:  m_target = w.write_data;
                    default:     r.bad_offset = 1'b1;
                endcase
            end
            CMD_TICK: begin
                if (m_play) begin
                    span = m_rate_fast ? period_fast : period_slow;
                    if (span == '0)
                        span = PERIOD_W'(1);
                    m_accum = m_accum + 1'b1;
                    if (m_accum >= span) begin
                        m_accum = '0;
                        m_count = m_count + 1;
                        if (m_match && m_count >= m_target)
                            m_status = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        r.irq_line      = m_status & m_mask;
        r.stream_enable = m_play;
        r.dma_rate_slow = m_dma;
        return r;
    endfunction

    function automatic t_aif_in bus_word(input logic [1:0] cmd, input logic [15:0] ofs,
                                         input logic [31:0] data);
        t_aif_in w;
        w.cmd        = cmd;
        w.reg_offset = ofs;
        w.write_data = data;
        return w;
    endfunction

    function automatic logic [15:0] known_offset();
        case ($urandom_range(3))
            0:       return OFS_CONTROL;
            1:       return OFS_VOLUME;
            2:       return OFS_COUNTER;
            default: return OFS_TARGET;
        endcase
    endfunction

    // Ticks are the most common word, with playback mostly kept running, so the counter moves and matches fire.
    function automatic t_aif_in random_bus_word();
        t_aif_in     w;
        int          pick;
        logic [31:0] data;
        pick = $urandom_range(99);
        w    = bus_word(CMD_TICK, 16'($urandom_range(16'hFFFF)), $urandom);
        if (pick >= 45 && pick < 60) begin
            w.cmd        = CMD_READ;
            w.reg_offset = known_offset();
        end else if (pick >= 60 && pick < 90) begin
            w.cmd        = CMD_WRITE;
            w.reg_offset = known_offset();
            data         = $urandom;
            case (w.reg_offset)
                OFS_CONTROL: begin
                    data[CTL_PLAY]   = ($urandom_range(99) < 85);
                    data[CTL_STROBE] = ($urandom_range(99) < 5);
                end
                OFS_TARGET:  if ($urandom_range(3) != 0) data = m_count + $urandom_range(6);
                OFS_COUNTER: if ($urandom_range(3) != 0) data = $urandom_range(40);
                default: ;
            endcase
            w.write_data = data;
        end else if (pick >= 90 && pick < 95) begin
            w.cmd = CMD_NOP;
        end else if (pick >= 95) begin
            w.cmd = $urandom_range(1) ? CMD_WRITE : CMD_READ;
        end
        return w;
    endfunction

    task automatic send_word(input t_aif_in w);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        expected_words.push_back(apply_bus_word(w));
    endtask

    // Lets every outstanding word come back, then keeps the input idle before returning.
    task automatic wait_drained();
        int guard;
        guard = 0;
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (expected_words.size() != 0 && guard < DRAIN_LIMIT) begin
            @(posedge i_clk);
            guard++;
        end
        if (expected_words.size() != 0) begin
            $display("%0d words never returned", expected_words.size());
            fault_count += expected_words.size();
            expected_words.delete();
        end
        repeat (6) @(negedge i_clk);
    endtask

    task automatic set_period(input logic idx, input logic [PERIOD_W-1:0] value);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(negedge i_clk);
        cfg_we   <= 1'b0;
        if (idx == CFG_FAST)
            period_fast = value;
        else
            period_slow = value;
    endtask

    task automatic test_reset_state();
        send_word(bus_word(CMD_READ, OFS_CONTROL, '0));
        send_word(bus_word(CMD_READ, OFS_VOLUME, '0));
        send_word(bus_word(CMD_READ, OFS_COUNTER, '0));
        send_word(bus_word(CMD_READ, OFS_TARGET, '0));
        send_word(bus_word(CMD_READ, 16'h0000, '0));
        send_word(bus_word(CMD_WRITE, 16'hFFFF, 32'hFFFF_FFFF));
        send_word(bus_word(CMD_NOP, 16'hFFFF, 32'hFFFF_FFFF));
    endtask

    task automatic test_register_access();
        send_word(bus_word(CMD_WRITE, OFS_VOLUME, 32'hFFFF_FFFF));
        send_word(bus_word(CMD_READ, OFS_VOLUME, '0));
        send_word(bus_word(CMD_WRITE, OFS_TARGET, '0));
        send_word(bus_word(CMD_WRITE, OFS_COUNTER, 32'hFFFF_FFFF));
        send_word(bus_word(CMD_READ, OFS_COUNTER, '0));
        wait_drained();
    endtask

    // Playback with a one-tick period: match, status clear, counter wrap, stop.
    task automatic test_playback();
        set_period(CFG_FAST, 20'd1);
        send_word(bus_word(CMD_WRITE, OFS_CONTROL, 32'h0000_007F));
        send_word(bus_word(CMD_TICK, '0, '0));
        send_word(bus_word(CMD_READ, OFS_CONTROL, '0));
        send_word(bus_word(CMD_WRITE, OFS_COUNTER, 32'hFFFF_FFFF));
        send_word(bus_word(CMD_TICK, '0, '0));
        send_word(bus_word(CMD_WRITE, OFS_CONTROL, 32'h0000_000F));
        send_word(bus_word(CMD_WRITE, OFS_CONTROL, '0));
        send_word(bus_word(CMD_TICK, '0, '0));
        wait_drained();
    endtask

    // A zero period acts as one; a period lowered under the accumulator completes at once.
    task automatic test_special_periods();
        set_period(CFG_FAST, 20'd0);
        set_period(CFG_SLOW, 20'd6);
        send_word(bus_word(CMD_WRITE, OFS_CONTROL, 32'h0000_0001));
        send_word(bus_word(CMD_TICK, '0, '0));
        send_word(bus_word(CMD_TICK, '0, '0));
        wait_drained();
        set_period(CFG_SLOW, 20'd1);
        send_word(bus_word(CMD_TICK, '0, '0));
        send_word(bus_word(CMD_WRITE, OFS_CONTROL, 32'h0000_0003));
        send_word(bus_word(CMD_TICK, '0, '0));
        wait_drained();
    endtask

    task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                       input logic [PERIOD_W-1:0] fast,
                                       input logic [PERIOD_W-1:0] slow);
        set_period(CFG_FAST, fast);
        set_period(CFG_SLOW, slow);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (WORDS_PER_PHASE)
            send_word(random_bus_word());
        wait_drained();
    endtask

    always @(negedge i_clk)
        out_ready <= ($urandom_range(99) >= recv_stall_pct);

    task automatic note_fault(input string what, input logic [31:0] want,
                              input logic [31:0] got);
        fault_count++;
        if (fault_count <= REPORT_LIMIT)
            $display("%0t: %s: expected %h, got %h", $realtime, what, want, got);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && out_ready) begin
            if (expected_words.size() == 0) begin
                note_fault("word with none expected", '0, o_out.read_data);
            end else begin
                oldest_word = expected_words.pop_front();
                if (o_out.read_data !== oldest_word.read_data)
                    note_fault("read_data", oldest_word.read_data, o_out.read_data);
                if (o_out.bad_offset !== oldest_word.bad_offset)
                    note_fault("bad_offset", 32'(oldest_word.bad_offset),
                               32'(o_out.bad_offset));
                if (o_out.irq_line !== oldest_word.irq_line)
                    note_fault("irq_line", 32'(oldest_word.irq_line),
                               32'(o_out.irq_line));
                if (o_out.stream_enable !== oldest_word.stream_enable)
                    note_fault("stream_enable", 32'(oldest_word.stream_enable),
                               32'(o_out.stream_enable));
                if (o_out.dma_rate_slow !== oldest_word.dma_rate_slow)
                    note_fault("dma_rate_slow", 32'(oldest_word.dma_rate_slow),
                               32'(o_out.dma_rate_slow));
            end
        end
    end

    initial begin
        i_rst_n   = 1'b0;
        in_valid  = 1'b0;
        in_word   = '0;
        cfg_we    = 1'b0;
        cfg_idx   = CFG_FAST;
        cfg_data  = '0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_register_access();
        test_playback();
        test_special_periods();
        test_random_traffic(0, 0, 20'd2, 20'd3);
        test_random_traffic(84, 0, 20'd1, 20'hFFFFF);
        test_random_traffic(0, 84, 20'd0, 20'd5);
        test_random_traffic(29, 29, 20'd4, 20'd1);

        if (fault_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
